// ===== hdl/cft_pkg.sv =====
// Shared types, character codes and the per-byte parse step of the CSV tokenizer.
`timescale 1ns / 1ps
package cft_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [15:0] TALLY_MAX = 16'hFFFF;
  localparam logic [1:0]  MAX_RES   = 2'd3;

  typedef enum logic [2:0] {
    MODE_BETWEEN    = 3'd0,
    MODE_PLAIN      = 3'd1,
    MODE_QUOTED     = 3'd2,
    MODE_QUOTE_SEEN = 3'd3,
    MODE_CR_SEEN    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_END_FIELD  = 2'd1,
    KIND_END_RECORD = 2'd2
  } kind_t;

  typedef struct packed {
    mode_t       mode;
    logic        closed;
    logic [15:0] tally;
  } state_t;

  // All results of one request; at most one data byte and one record end per request.
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][1:0] kinds;
    logic [7:0]      data;
    logic [15:0]     tally;
  } bundle_t;

  typedef struct packed {
    state_t  st;
    bundle_t res;
  } step_t;

  function automatic logic [15:0] sat_inc(logic [15:0] t);
    return (t == TALLY_MAX) ? t : t + 16'd1;
  endfunction

  function automatic bundle_t add_kind(bundle_t b, kind_t k);
    bundle_t r;
    r = b;
    if (r.n != MAX_RES) begin
      r.kinds[r.n] = k;
      r.n = r.n + 2'd1;
    end
    return r;
  endfunction

  function automatic step_t close_field(step_t x);
    step_t r;
    r = x;
    r.st.tally  = sat_inc(r.st.tally);
    r.res       = add_kind(r.res, KIND_END_FIELD);
    r.st.closed = 1'b1;
    r.st.mode   = MODE_BETWEEN;
    return r;
  endfunction

  function automatic step_t end_record(step_t x);
    step_t r;
    r = x;
    if (!r.st.closed) begin
      r.st.tally = sat_inc(r.st.tally);
      r.res      = add_kind(r.res, KIND_END_FIELD);
    end
    r.st.closed = 1'b0;
    r.res.tally = r.st.tally;
    r.res       = add_kind(r.res, KIND_END_RECORD);
    r.st.tally  = 16'd0;
    r.st.mode   = MODE_BETWEEN;
    return r;
  endfunction

  function automatic step_t handle_between(step_t x, logic [7:0] c);
    step_t r;
    r = x;
    if (c == CH_CR) begin
      r.st.mode = MODE_CR_SEEN;
    end else if (c == CH_LF) begin
      r = end_record(r);
    end else if (c == CH_COMMA) begin
      if (!r.st.closed) begin
        r.st.tally = sat_inc(r.st.tally);
        r.res      = add_kind(r.res, KIND_END_FIELD);
      end
      r.st.closed = 1'b0;
    end else if (c == CH_QUOTE) begin
      r.st.mode = MODE_QUOTED;
    end else begin
      r.st.mode = MODE_PLAIN;
      r.res     = add_kind(r.res, KIND_DATA);
    end
    return r;
  endfunction

  // One byte through the parser: next state and the results it causes.
  function automatic step_t parse_step(state_t s, logic [7:0] c);
    step_t r;
    logic  again;
    r          = '0;
    r.st       = s;
    r.res.data = c;
    again      = 1'b0;
    unique case (s.mode)
      MODE_PLAIN: begin
        if (c == CH_COMMA || c == CH_LF || c == CH_CR) begin
          r     = close_field(r);
          again = 1'b1;
        end else begin
          r.res = add_kind(r.res, KIND_DATA);
        end
      end
      MODE_QUOTED: begin
        if (c == CH_QUOTE) begin
          r.st.mode = MODE_QUOTE_SEEN;
        end else begin
          r.res = add_kind(r.res, KIND_DATA);
        end
      end
      MODE_QUOTE_SEEN: begin
        if (c == CH_QUOTE) begin
          r.res     = add_kind(r.res, KIND_DATA);
          r.st.mode = MODE_QUOTED;
        end else begin
          r     = close_field(r);
          again = 1'b1;
        end
      end
      MODE_CR_SEEN: begin
        r     = end_record(r);
        again = (c != CH_LF);
      end
      default: begin
        r.st.mode = MODE_BETWEEN;
        again     = 1'b1;
      end
    endcase
    if (again) begin
      r = handle_between(r, c);
    end
    return r;
  endfunction

endpackage

// ===== hdl/cft_front.sv =====
// Front end: accepts bytes, runs the parse step and pushes result bundles.
`timescale 1ns / 1ps
module cft_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        byte_req,
  input  logic              q_full,
  output logic              push,
  output cft_pkg::bundle_t  push_data
);

  cft_pkg::state_t state;
  cft_pkg::step_t  step;
  logic            accept;

  always_comb begin
    step = cft_pkg::parse_step(state, byte_req);
  end

  assign in_stall  = q_full | rst;
  assign accept    = in_valid & ~in_stall;
  assign push      = accept & (step.res.n != 2'd0);
  assign push_data = step.res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode   <= cft_pkg::MODE_BETWEEN;
      state.closed <= 1'b0;
      state.tally  <= 16'd0;
    end else if (accept) begin
      state <= step.st;
    end
  end

endmodule

// ===== hdl/cft_queue.sv =====
// Bundle queue between the front end and the output sequencer.
`timescale 1ns / 1ps
module cft_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cft_pkg::bundle_t  push_data,
  output logic              full,
  input  logic              pop,
  output cft_pkg::bundle_t  pop_data,
  output logic              nonempty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cft_pkg::bundle_t slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full bundle queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("pop from empty bundle queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("bundle queue count out of range");
`endif

endmodule

// ===== hdl/cft_back.sv =====
// Output sequencer: holds one bundle and issues its results one per cycle when not stalled.
`timescale 1ns / 1ps
module cft_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              nonempty,
  input  cft_pkg::bundle_t  pop_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [7:0]        data_byte,
  output logic [15:0]       fields_in_record,
  output logic              last
);

  cft_pkg::bundle_t cur;
  logic             cur_valid;
  logic [1:0]       idx;
  logic             take;
  logic             done;

  assign out_valid        = cur_valid;
  assign kind             = cur.kinds[idx];
  assign last             = (idx == cur.n - 2'd1);
  assign data_byte        = (kind == cft_pkg::KIND_DATA) ? cur.data : 8'd0;
  assign fields_in_record = (kind == cft_pkg::KIND_END_RECORD) ? cur.tally : 16'd0;

  assign take = cur_valid & ~out_stall;
  assign done = ~cur_valid | (take & last);
  assign pop  = done & nonempty;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= nonempty;
      idx       <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.n != 2'd0) && (idx < cur.n))
    else $error("result index outside held bundle");
`endif

endmodule

// ===== hdl/csv_field_tokenizer.sv =====
// Top level of the CSV field tokenizer: front end, bundle queue, output sequencer.
// Path: a request accepted at a clock edge is written into the queue at that edge;
//   its bundle is then loaded from the queue into the output register, and its first
//   result is offered from that register; the queue absorbs bursts.
// Throughput: one request per cycle while each request gives at most one result
//   and out_stall is low; a request with more holds the output until all are taken.
// Reset (rst, synchronous): parser state between fields, count zero, queue and output empty.
`timescale 1ns / 1ps
module csv_field_tokenizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] fields_in_record,
  output logic        last
);

  // Front end to queue: one bundle per accepted request that has any result.
  logic             push;
  cft_pkg::bundle_t push_data;
  logic             q_full;

  // Queue to output sequencer.
  logic             pop;
  cft_pkg::bundle_t pop_data;
  logic             nonempty;

  // Parse each request combinationally; stall when the queue is full or in reset.
  cft_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .byte_req  (byte_req),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple the parser from output back pressure.
  cft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .nonempty  (nonempty)
  );

  // Serialize bundles into results; the last result of a bundle carries last.
  cft_back u_back (
    .clk              (clk),
    .rst              (rst),
    .nonempty         (nonempty),
    .pop_data         (pop_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .data_byte        (data_byte),
    .fields_in_record (fields_in_record),
    .last             (last)
  );

endmodule

// ===== bench/csv_field_tokenizer_tb.sv =====
// Self-checking testbench of the CSV field tokenizer: directed rows and random records.
`timescale 1ns / 1ps
module csv_field_tokenizer_tb;

  // One result of the tokenizer as it shows on the output ports.
  typedef struct packed {
    cft_pkg::kind_t kind;
    logic [7:0]     data;
    logic [15:0]    count;
    logic           is_last;
  } token_t;

  // One directed request: the byte and, where it is plain to see, its results.
  typedef struct {
    logic [7:0] c;
    int         cnt;
    token_t     t0;
    token_t     t1;
  } stim_row_t;

  localparam int     BY_MODEL     = -1;    // row results come from the predictor
  localparam int     IDLE_PCT     = 24;
  localparam int     RANDOM_ITEMS = 375;
  localparam int     CALM_ITEMS   = 150;   // random bytes sent with no idling
  localparam int     HOLD_AT      = 100;   // results seen when the long hold-off starts
  localparam int     HOLD_LEN     = 300;
  localparam int     QUIET_LIMIT  = 5000;
  localparam int     TAIL_CYCLES  = 10;
  localparam token_t NIL          = '0;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_req  = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] fields_in_record;
  logic        last;

  // Predictor state: parse mode, field just closed, fields in the current record.
  cft_pkg::mode_t tok_mode   = cft_pkg::MODE_BETWEEN;
  logic           tok_closed = 1'b0;
  logic [15:0]    tok_tally  = 16'h0000;
  token_t         step_toks[$];       // results of the byte being predicted
  token_t         pending_tokens[$];  // results the block still owes, oldest first
  stim_row_t      stim_rows[$];

  int  mismatches   = 0;
  int  bytes_sent   = 0;
  int  results_seen = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  bit  calm         = 1'b0;        // suppress idling on both sides
  int  quiet_cycles = 0;

  csv_field_tokenizer i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .byte_req         (byte_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .data_byte        (data_byte),
    .fields_in_record (fields_in_record),
    .last             (last)
  );

  always #1 clk = ~clk;

  function automatic token_t tok(cft_pkg::kind_t k, logic [7:0] d, logic [15:0] n);
    token_t t;
    t.kind    = k;
    t.data    = d;
    t.count   = n;
    t.is_last = 1'b0;
    return t;
  endfunction

  function automatic stim_row_t mk_row(logic [7:0] c, int cnt, token_t t0, token_t t1);
    stim_row_t r;
    r.c   = c;
    r.cnt = cnt;
    r.t0  = t0;
    r.t1  = t1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor. One byte in, up to three tokens out into step_toks.
  // ---------------------------------------------------------------------------
  function void put_token(cft_pkg::kind_t k, logic [7:0] d, logic [15:0] n);
    if (step_toks.size() < 3) begin
      step_toks.push_back(tok(k, d, n));
    end
  endfunction

  // Hold the count at its top value instead of wrapping.
  function void count_field_once();
    if (tok_tally != 16'hFFFF) begin
      tok_tally = tok_tally + 16'd1;
    end
  endfunction

  function void seal_field();
    count_field_once();
    put_token(cft_pkg::KIND_END_FIELD, 8'h00, 16'h0000);
    tok_closed = 1'b1;
    tok_mode   = cft_pkg::MODE_BETWEEN;
  endfunction

  // A record end also ends a field unless one was closed just now.
  function void seal_record();
    if (!tok_closed) begin
      count_field_once();
      put_token(cft_pkg::KIND_END_FIELD, 8'h00, 16'h0000);
    end
    tok_closed = 1'b0;
    put_token(cft_pkg::KIND_END_RECORD, 8'h00, tok_tally);
    tok_tally = 16'h0000;
    tok_mode  = cft_pkg::MODE_BETWEEN;
  endfunction

  function void at_boundary(logic [7:0] c);
    if (c == cft_pkg::CH_CR) begin
      tok_mode = cft_pkg::MODE_CR_SEEN;
    end else if (c == cft_pkg::CH_LF) begin
      seal_record();
    end else if (c == cft_pkg::CH_COMMA) begin
      // a comma right after a closed field adds no empty field
      if (!tok_closed) begin
        count_field_once();
        put_token(cft_pkg::KIND_END_FIELD, 8'h00, 16'h0000);
      end
      tok_closed = 1'b0;
    end else if (c == cft_pkg::CH_QUOTE) begin
      tok_mode = cft_pkg::MODE_QUOTED;
    end else begin
      tok_mode = cft_pkg::MODE_PLAIN;
      put_token(cft_pkg::KIND_DATA, c, 16'h0000);
    end
  endfunction

  function void tokenize_byte(logic [7:0] c);
    step_toks.delete();
    case (tok_mode)
      cft_pkg::MODE_PLAIN: begin
        if (c == cft_pkg::CH_COMMA || c == cft_pkg::CH_LF || c == cft_pkg::CH_CR) begin
          seal_field();
          at_boundary(c);
        end else begin
          put_token(cft_pkg::KIND_DATA, c, 16'h0000);
        end
      end
      cft_pkg::MODE_QUOTED: begin
        if (c == cft_pkg::CH_QUOTE) begin
          tok_mode = cft_pkg::MODE_QUOTE_SEEN;
        end else begin
          put_token(cft_pkg::KIND_DATA, c, 16'h0000);
        end
      end
      cft_pkg::MODE_QUOTE_SEEN: begin
        // doubled quote gives one quote; anything else closes the quoted field
        if (c == cft_pkg::CH_QUOTE) begin
          put_token(cft_pkg::KIND_DATA, c, 16'h0000);
          tok_mode = cft_pkg::MODE_QUOTED;
        end else begin
          seal_field();
          at_boundary(c);
        end
      end
      cft_pkg::MODE_CR_SEEN: begin
        // the pending CR ends the record; an LF after it is swallowed
        seal_record();
        if (c != cft_pkg::CH_LF) begin
          at_boundary(c);
        end
      end
      default: begin
        tok_mode = cft_pkg::MODE_BETWEEN;
        at_boundary(c);
      end
    endcase
    if (step_toks.size() > 0) begin
      step_toks[step_toks.size() - 1].is_last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------
  // Idle at random, then offer the byte and hold it until the block takes it.
  task automatic offer_byte(logic [7:0] c);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_req <= c;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  // Offer a byte and queue what the predictor says it causes.
  task automatic feed_byte(logic [7:0] c);
    offer_byte(c);
    tokenize_byte(c);
    foreach (step_toks[i]) begin
      pending_tokens.push_back(step_toks[i]);
    end
  endtask

  // Any byte but a separator or a line end.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == cft_pkg::CH_COMMA || b == cft_pkg::CH_LF || b == cft_pkg::CH_CR) begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  // One well-formed record with random fields and a random line end.
  task automatic send_record();
    int         nf;
    int         len;
    int         pick;
    logic [7:0] b;
    nf = $urandom_range(1, 5);
    for (int f = 0; f < nf; f++) begin
      pick = $urandom_range(9);
      if (pick >= 2 && pick <= 6) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          feed_byte(plain_byte());
        end
      end else if (pick >= 7) begin
        feed_byte(cft_pkg::CH_QUOTE);
        len = $urandom_range(0, 5);
        for (int i = 0; i < len; i++) begin
          b = ($urandom_range(3) == 0) ? cft_pkg::CH_QUOTE : 8'($urandom_range(255));
          feed_byte(b);
          if (b == cft_pkg::CH_QUOTE) begin
            feed_byte(cft_pkg::CH_QUOTE);
          end
        end
        feed_byte(cft_pkg::CH_QUOTE);
      end
      if (f != nf - 1) begin
        feed_byte(cft_pkg::CH_COMMA);
      end
    end
    pick = $urandom_range(2);
    if (pick == 0) begin
      feed_byte(cft_pkg::CH_LF);
    end else if (pick == 1) begin
      feed_byte(cft_pkg::CH_CR);
      feed_byte(cft_pkg::CH_LF);
    end else begin
      feed_byte(cft_pkg::CH_CR);
    end
  endtask

  // A few bytes of noise, rich in quotes, commas and line ends.
  task automatic send_noise();
    int         n;
    logic [7:0] b;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0:       b = cft_pkg::CH_QUOTE;
        1:       b = cft_pkg::CH_COMMA;
        2:       b = cft_pkg::CH_LF;
        3:       b = cft_pkg::CH_CR;
        default: b = 8'($urandom_range(255));
      endcase
      feed_byte(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("MISMATCH t=%0t result %0d: %s", $time, results_seen, msg);
  endtask

  // Compare one accepted result with the oldest pending token.
  task automatic check_token();
    token_t want;
    results_seen++;
    if (pending_tokens.size() == 0) begin
      flag_mismatch($sformatf("unexpected result kind %0d", kind));
      return;
    end
    want = pending_tokens.pop_front();
    if (kind !== want.kind) begin
      flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
    end
    if (data_byte !== want.data) begin
      flag_mismatch($sformatf("data_byte %h, want %h", data_byte, want.data));
    end
    if (fields_in_record !== want.count) begin
      flag_mismatch($sformatf("fields_in_record %0d, want %0d", fields_in_record, want.count));
    end
    if (last !== want.is_last) begin
      flag_mismatch($sformatf("last %b, want %b", last, want.is_last));
    end
  endtask

  // Take results, stall at random, and once hold off for a long stretch so the
  // block fills up and stalls its input.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      check_token();
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (!calm && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("csv_field_tokenizer_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    token_t t0;
    token_t t1;
    int     base;

    // Plain fields with the byte extremes, empty fields, no-result bytes.
    stim_rows.push_back(mk_row(8'h61, 1, tok(cft_pkg::KIND_DATA, 8'h61, 16'd0), NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_COMMA, 1,
                               tok(cft_pkg::KIND_END_FIELD, 8'h00, 16'd0), NIL));
    stim_rows.push_back(mk_row(8'h00, 1, tok(cft_pkg::KIND_DATA, 8'h00, 16'd0), NIL));
    stim_rows.push_back(mk_row(8'hFF, 1, tok(cft_pkg::KIND_DATA, 8'hFF, 16'd0), NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_LF, 2, tok(cft_pkg::KIND_END_FIELD, 8'h00, 16'd0),
                               tok(cft_pkg::KIND_END_RECORD, 8'h00, 16'd2)));
    stim_rows.push_back(mk_row(cft_pkg::CH_COMMA, 1,
                               tok(cft_pkg::KIND_END_FIELD, 8'h00, 16'd0), NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_LF, 2, tok(cft_pkg::KIND_END_FIELD, 8'h00, 16'd0),
                               tok(cft_pkg::KIND_END_RECORD, 8'h00, 16'd2)));
    stim_rows.push_back(mk_row(cft_pkg::CH_QUOTE, 0, NIL, NIL));
    // Quoted field with a doubled quote and a comma inside.
    stim_rows.push_back(mk_row(8'h78, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_QUOTE, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_QUOTE, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_COMMA, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_QUOTE, BY_MODEL, NIL, NIL));
    // Ordinary byte after the closing quote starts a new plain field.
    stim_rows.push_back(mk_row(8'h62, BY_MODEL, NIL, NIL));
    // Lone CR, CR after CR, and a byte after CR that yields three results.
    stim_rows.push_back(mk_row(cft_pkg::CH_CR, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_CR, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(8'h71, BY_MODEL, NIL, NIL));
    // CR LF pair.
    stim_rows.push_back(mk_row(cft_pkg::CH_CR, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_LF, BY_MODEL, NIL, NIL));
    // Empty quoted field, then a comma right after the closed field.
    stim_rows.push_back(mk_row(cft_pkg::CH_QUOTE, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_QUOTE, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_COMMA, BY_MODEL, NIL, NIL));
    // CR inside quotes is data; LF after the closing quote ends the record.
    stim_rows.push_back(mk_row(cft_pkg::CH_QUOTE, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_CR, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_QUOTE, BY_MODEL, NIL, NIL));
    stim_rows.push_back(mk_row(cft_pkg::CH_LF, BY_MODEL, NIL, NIL));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed rows; typed rows override the predictor's tokens but
    // still advance its state.
    foreach (stim_rows[r]) begin
      offer_byte(stim_rows[r].c);
      tokenize_byte(stim_rows[r].c);
      if (stim_rows[r].cnt == BY_MODEL) begin
        foreach (step_toks[i]) begin
          pending_tokens.push_back(step_toks[i]);
        end
      end else begin
        t0 = stim_rows[r].t0;
        t1 = stim_rows[r].t1;
        if (stim_rows[r].cnt == 1) begin
          t0.is_last = 1'b1;
          pending_tokens.push_back(t0);
        end else if (stim_rows[r].cnt == 2) begin
          t1.is_last = 1'b1;
          pending_tokens.push_back(t0);
          pending_tokens.push_back(t1);
        end
      end
    end

    // Random records, mostly well formed, with some noise between them.
    // Run the first stretch with no idling on either side.
    base = bytes_sent;
    while (bytes_sent - base < RANDOM_ITEMS) begin
      calm = (bytes_sent - base < CALM_ITEMS);
      if ($urandom_range(99) < 15) begin
        send_noise();
      end else begin
        send_record();
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain, then give the block a few more cycles to show anything extra.
    while (pending_tokens.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes (directed rows, then %0d random, the first %0d unthrottled)",
             bytes_sent, bytes_sent - base, CALM_ITEMS);
    $display("and %0d results checked, with one %0d-cycle output hold-off.",
             results_seen, HOLD_LEN);
    if (mismatches == 0) begin
      $display("csv_field_tokenizer_tb: clean");
    end else begin
      $display("csv_field_tokenizer_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cft_pkg.sv
hdl/cft_front.sv
hdl/cft_queue.sv
hdl/cft_back.sv
hdl/csv_field_tokenizer.sv
bench/csv_field_tokenizer_tb.sv
